### rtl/stlru_pkg.sv
// Shared types and constants for the sampler tag table.
// No dependencies; imported by every module of the block except stlru_ram.
`timescale 1ns / 1ps

package stlru_pkg;

  localparam int NUM_SETS = 64;
  localparam int NUM_WAYS = 8;
  localparam int SIG_BITS = 16;
  localparam int AGE_BITS = 8;

  localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int ENTRIES = NUM_SETS * NUM_WAYS;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CMP_W   = (AGE_BITS > 8) ? AGE_BITS : 8;

  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  localparam logic [2:0] CMD_FIND   = 3'd0;
  localparam logic [2:0] CMD_VICTIM = 3'd1;
  localparam logic [2:0] CMD_ALLOC  = 3'd2;
  localparam logic [2:0] CMD_AGE    = 3'd3;
  localparam logic [2:0] CMD_WRITE  = 3'd4;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [5:0]  set_index;
    logic [15:0] signature;
    logic [7:0]  age_limit;
    logic [2:0]  way_select;
    logic        write_valid;
    logic [7:0]  write_age;
  } req_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] way_found;
    logic       way_given;
  } rsp_t;

  typedef struct packed {
    logic                valid;
    logic [SIG_BITS-1:0] sig;
    logic [AGE_BITS-1:0] age;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_WRITE,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic load_item;
    logic scan_issue;
    logic do_write;
    logic load_result;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic scan_last;
    logic in_scan;
    logic in_write;
  } dp_stat_t;

endpackage

### rtl/stlru_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module stlru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/stlru_ctrl.sv
// Controller: sequences clearing, way scans, writes and result hand-off.
// Depends on stlru_pkg.
`timescale 1ns / 1ps

module stlru_ctrl import stlru_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  ctl
);

  state_t state, state_next;
  logic   out_free;

  assign out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          if (stat.in_scan)       state_next = ST_SCAN;
          else if (stat.in_write) state_next = ST_WRITE;
          else                    state_next = ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (stat.scan_last) state_next = ST_TAIL;
      end
      ST_TAIL:   state_next = ST_FINISH;
      ST_WRITE:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    ctl       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_CLEAR:  ctl.clear_step = 1'b1;
      ST_IDLE: begin
        req_ready     = 1'b1;
        ctl.load_item = req_valid;
      end
      ST_SCAN:   ctl.scan_issue  = 1'b1;
      ST_TAIL:   ;
      ST_WRITE:  ctl.do_write    = 1'b1;
      ST_FINISH: ctl.load_result = out_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.load_result) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state != ST_IDLE))
    else $error("accepted transaction did not start work");

  a_tail_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TAIL) |-> ($past(state) == ST_SCAN))
    else $error("tail cycle without a preceding scan");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == ST_FINISH))
    else $error("result raised outside the finish step");

endmodule

### rtl/stlru_dpath.sv
// Datapath: request register, way scan pipeline, trackers, result register.
// Depends on stlru_pkg and stlru_ram.
`timescale 1ns / 1ps

module stlru_dpath import stlru_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  req_t     req,
  input  dp_cmd_t  ctl,
  output dp_stat_t stat,
  output rsp_t     rsp
);

  req_t               item;
  logic [SET_W-1:0]   set_r;
  logic [ADDR_W-1:0]  clr_cnt;
  logic [WAY_W-1:0]   rd_cnt;
  logic               pend;
  logic [WAY_W-1:0]   pend_way;

  logic               match_found;
  logic [WAY_W-1:0]   match_way;
  logic               inval_found;
  logic [WAY_W-1:0]   inval_way;
  logic [WAY_W-1:0]   best_way;
  logic [AGE_BITS-1:0] best_age;

  logic [ADDR_W-1:0]  base;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               ram_we;
  entry_t             rd;
  entry_t             wr_entry;
  logic               sig_hit;
  logic               age_inc;
  logic               way_ok;
  logic [WAY_W-1:0]   victim_way;
  rsp_t               res;

  assign base      = ADDR_W'(ADDR_W'(set_r) * ADDR_W'(NUM_WAYS));
  assign ram_raddr = base + ADDR_W'(rd_cnt);
  assign rd        = entry_t'(ram_rdata);
  assign sig_hit   = rd.valid && (rd.sig == SIG_BITS'(item.signature));
  assign age_inc   = rd.valid && (CMP_W'(rd.age) < CMP_W'(item.age_limit))
                     && (rd.age != AGE_MAX);
  assign way_ok    = (32'(item.way_select) < NUM_WAYS);

  stlru_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // decode the incoming request and the counter ends for the controller
  always_comb begin
    stat.in_scan    = 1'b0;
    stat.in_write   = 1'b0;
    stat.clear_last = (clr_cnt == ADDR_W'(ENTRIES - 1));
    stat.scan_last  = (rd_cnt == WAY_W'(NUM_WAYS - 1));
    unique case (req.cmd) inside
      CMD_FIND, CMD_VICTIM, CMD_ALLOC, CMD_AGE: stat.in_scan  = 1'b1;
      CMD_WRITE:                                stat.in_write = 1'b1;
      default:                                  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      pend    <= 1'b0;
    end else begin
      pend <= ctl.scan_issue;
      if (ctl.clear_step) clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    pend_way <= rd_cnt;
    if (ctl.load_item) begin
      item   <= req;
      set_r  <= SET_W'(req.set_index % NUM_SETS);
      rd_cnt <= '0;
    end else if (ctl.scan_issue) begin
      rd_cnt <= rd_cnt + 1'b1;
    end
  end

  // trackers: first match, first invalid way, oldest way (ties to lowest)
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      match_found <= 1'b0;
      inval_found <= 1'b0;
    end else if (pend) begin
      if (sig_hit && !match_found) begin
        match_found <= 1'b1;
        match_way   <= pend_way;
      end
      if (!rd.valid && !inval_found) begin
        inval_found <= 1'b1;
        inval_way   <= pend_way;
      end
      if (pend_way == '0 || rd.age > best_age) begin
        best_way <= pend_way;
        best_age <= rd.age;
      end
    end
  end

  // one write port: clearing pass, direct load, or age write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt;
    wr_entry  = '0;
    if (ctl.clear_step) begin
      ram_we = 1'b1;
    end else if (ctl.do_write) begin
      ram_we         = way_ok;
      ram_waddr      = base + ADDR_W'(item.way_select);
      wr_entry.valid = item.write_valid;
      wr_entry.sig   = SIG_BITS'(item.signature);
      wr_entry.age   = AGE_BITS'(item.write_age);
    end else if (pend && item.cmd == CMD_AGE) begin
      ram_we       = age_inc;
      ram_waddr    = base + ADDR_W'(pend_way);
      wr_entry     = rd;
      wr_entry.age = rd.age + 1'b1;
    end
  end

  assign victim_way = inval_found ? inval_way : best_way;

  always_comb begin
    res = '0;
    unique case (item.cmd)
      CMD_FIND: begin
        res.hit       = match_found;
        res.way_found = match_found ? 3'(match_way) : 3'd0;
        res.way_given = match_found;
      end
      CMD_VICTIM: begin
        res.way_found = 3'(victim_way);
        res.way_given = 1'b1;
      end
      CMD_ALLOC: begin
        res.hit       = match_found;
        res.way_found = match_found ? 3'(match_way) : 3'(victim_way);
        res.way_given = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load_result) rsp <= res;
  end

  a_write_port_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.do_write || ctl.clear_step) |-> !pend)
    else $error("write port collision with age write-back");

  a_clear_exclusive: assert property (@(posedge clk) disable iff (rst)
    ctl.clear_step |-> !(ctl.load_item || ctl.scan_issue || ctl.load_result))
    else $error("work issued during clearing pass");

endmodule

### rtl/sampler_tag_table_lru.sv
// Sampler tag table with LRU victim choice, one set scanned a way per cycle.
//
// Request channel (req_valid/req_ready/req) carries find, victim, allocate,
// age and write-way commands for one set; the response channel
// (rsp_valid/rsp_ready/rsp) returns exactly one result per transaction:
// hit, way_found and way_given.
// Find, victim, allocate and age visit every way of the set through the
// single read port of the table RAM, one way per cycle; write goes straight
// to its way and an unknown command straight to the finish step. A request
// is taken only once the one before it has left the finish step.
// rsp_valid is registered and rises once the finish step loads the result.
// The result sits in an output register; the next request is taken while it
// waits. If the receiver stalls, the following result holds in the finish
// step until the output register frees.
// Reset: a clearing pass writes every one of the NUM_SETS * NUM_WAYS entries
// to zero, one per cycle; req_ready stays low until it ends.
// Depends on stlru_pkg, stlru_ctrl, stlru_dpath and stlru_ram.
`timescale 1ns / 1ps

module sampler_tag_table_lru_core import stlru_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  stlru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  stlru_dpath u_dpath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .ctl  (ctl),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

### bench/sampler_tag_table_lru_checker.sv
// Checker for the sampler tag table: watches both channels, keeps its own copy
// of the table, predicts each result and compares it field by field.
// Depends on stlru_pkg for the transaction types and command codes.
`timescale 1ns / 1ps

module sampler_tag_table_lru_checker import stlru_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   fail_count,
  output int   pending
);

  logic                table_valid [ENTRIES];
  logic [SIG_BITS-1:0] table_sig   [ENTRIES];
  logic [AGE_BITS-1:0] table_age   [ENTRIES];

  rsp_t lookup_results_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // lowest valid way holding this signature
  function automatic bit match_way(int base, logic [SIG_BITS-1:0] sig, output int way);
    way = 0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (table_valid[base + w] && table_sig[base + w] == sig) begin
        way = w;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // first invalid way, else the oldest valid one; strict compare keeps ties low
  function automatic int pick_victim(int base);
    int oldest;
    oldest = 0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!table_valid[base + w]) return w;
      if (table_age[base + w] > table_age[base + oldest]) oldest = w;
    end
    return oldest;
  endfunction

  function automatic rsp_t apply_table_command(req_t r);
    rsp_t res;
    int   base;
    int   way;
    int   slot;
    res  = '0;
    way  = 0;
    base = (int'(r.set_index) % NUM_SETS) * NUM_WAYS;
    case (r.cmd)
      CMD_FIND: begin
        res.hit       = match_way(base, SIG_BITS'(r.signature), way);
        res.way_given = res.hit;
        if (res.hit) res.way_found = 3'(way);
      end
      CMD_VICTIM: begin
        res.way_found = 3'(pick_victim(base));
        res.way_given = 1'b1;
      end
      CMD_ALLOC: begin
        res.hit = match_way(base, SIG_BITS'(r.signature), way);
        if (!res.hit) way = pick_victim(base);
        res.way_found = 3'(way);
        res.way_given = 1'b1;
      end
      CMD_AGE: begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          slot = base + w;
          if (table_valid[slot] && table_age[slot] < r.age_limit &&
              table_age[slot] != AGE_MAX)
            table_age[slot] = table_age[slot] + 1'b1;
        end
      end
      CMD_WRITE: begin
        if (int'(r.way_select) < NUM_WAYS) begin
          slot              = base + int'(r.way_select);
          table_valid[slot] = r.write_valid;
          table_sig[slot]   = SIG_BITS'(r.signature);
          table_age[slot]   = AGE_BITS'(r.write_age);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void flag_field(string field, logic [2:0] want, logic [2:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int e = 0; e < ENTRIES; e++) begin
        table_valid[e] = 1'b0;
        table_sig[e]   = '0;
        table_age[e]   = '0;
      end
      lookup_results_q.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (lookup_results_q.size() == 0) begin
          $display("%0t: unexpected result transaction: expected none, got %h", $time, rsp);
          fail_count++;
        end else begin
          want = lookup_results_q.pop_front();
          flag_field("hit", 3'(want.hit), 3'(rsp.hit));
          flag_field("way_found", want.way_found, rsp.way_found);
          flag_field("way_given", 3'(want.way_given), 3'(rsp.way_given));
        end
      end
      if (req_valid && req_ready) lookup_results_q.push_back(apply_table_command(req));
    end
    pending = lookup_results_q.size();
  end

endmodule

### bench/sampler_tag_table_lru_core_tb.sv
// Testbench top for sampler_tag_table_lru_core: drives directed and random
// commands with random idling on both channels and gives the verdict.
// Depends on stlru_pkg, the block and sampler_tag_table_lru_checker.
`timescale 1ns / 1ps

module sampler_tag_table_lru_core_tb import stlru_pkg::*; ;

  localparam int         RESET_CYCLES = 7;
  localparam int         RANDOM_ITEMS = 1300;
  localparam int         LONG_HOLD    = 300;
  localparam int         DRAIN_CYCLES = 2 * (NUM_WAYS + 3);
  localparam int         CYCLE_LIMIT  = 1000000;
  localparam logic [2:0] CMD_RSVD_LO  = 3'd5;
  localparam logic [2:0] CMD_RSVD_HI  = 3'd7;
  localparam logic [15:0] SIG_POOL    = 16'hC3A0;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int fail_count;
  int pending;
  int cycle_count = 0;
  bit hold_rsp    = 1'b0;
  bit no_idle     = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sampler_tag_table_lru_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  sampler_tag_table_lru_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic req_t build_cmd(logic [2:0] cmd, logic [5:0] set_index,
                                     logic [15:0] sig, logic [7:0] lru,
                                     logic [2:0] way, logic wvalid, logic [7:0] wage);
    req_t r;
    r.cmd         = cmd;
    r.set_index   = set_index;
    r.signature   = sig;
    r.age_limit   = lru;
    r.way_select  = way;
    r.write_valid = wvalid;
    r.write_age   = wage;
    return r;
  endfunction

  function automatic logic [2:0] pick_cmd();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return CMD_WRITE;
    if (roll < 50) return CMD_FIND;
    if (roll < 70) return CMD_ALLOC;
    if (roll < 80) return CMD_VICTIM;
    if (roll < 93) return CMD_AGE;
    return 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
  endfunction

  // hold valid high across back-to-back transactions; lower it only for a gap
  task automatic send_cmd(input req_t r);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin : rsp_side
    int run_len;
    int stall_len;
    @(posedge clk);
    forever begin
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        rsp_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      run_len = ($urandom_range(0, 99) < 15) ? $urandom_range(30, 150) : $urandom_range(1, 8);
      rsp_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall_len = pick_gap();
      if (stall_len > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int          episode_set;
    logic [15:0] sig;
    logic [7:0]  wage;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // empty table: miss, lowest invalid way, allocate at the field extremes
    send_cmd(build_cmd(CMD_FIND, 6'd0, 16'h0000, 8'h00, 3'd0, 1'b0, 8'h00));
    send_cmd(build_cmd(CMD_VICTIM, 6'd0, 16'h0000, 8'h00, 3'd0, 1'b0, 8'h00));
    send_cmd(build_cmd(CMD_ALLOC, 6'd63, 16'hFFFF, 8'hFF, 3'd7, 1'b1, 8'hFF));

    // fill one set; ways 2 and 6 share the top age so the tie goes low
    for (int w = 0; w < NUM_WAYS; w++)
      send_cmd(build_cmd(CMD_WRITE, 6'd5, 16'hA000 + 16'(w), 8'h00, 3'(w), 1'b1,
                         (w == 2 || w == 6) ? 8'hFF : 8'(w * 3)));
    send_cmd(build_cmd(CMD_VICTIM, 6'd5, 16'h0000, 8'h00, 3'd0, 1'b0, 8'h00));
    send_cmd(build_cmd(CMD_FIND, 6'd5, 16'hA007, 8'h00, 3'd0, 1'b0, 8'h00));
    send_cmd(build_cmd(CMD_ALLOC, 6'd5, 16'hA003, 8'h00, 3'd0, 1'b0, 8'h00));
    send_cmd(build_cmd(CMD_ALLOC, 6'd5, 16'h1234, 8'h00, 3'd0, 1'b0, 8'h00));
    send_cmd(build_cmd(CMD_AGE, 6'd5, 16'h0000, 8'hFF, 3'd0, 1'b0, 8'h00));
    send_cmd(build_cmd(CMD_AGE, 6'd5, 16'h0000, 8'h00, 3'd0, 1'b0, 8'h00));

    // invalidated way keeps its signature but must not match
    send_cmd(build_cmd(CMD_WRITE, 6'd5, 16'hA004, 8'h00, 3'd4, 1'b0, 8'h00));
    send_cmd(build_cmd(CMD_VICTIM, 6'd5, 16'h0000, 8'h00, 3'd0, 1'b0, 8'h00));
    send_cmd(build_cmd(CMD_FIND, 6'd5, 16'hA004, 8'h00, 3'd0, 1'b0, 8'h00));

    // duplicate signature: the lower way wins
    send_cmd(build_cmd(CMD_WRITE, 6'd5, 16'hA001, 8'h00, 3'd6, 1'b1, 8'h00));
    send_cmd(build_cmd(CMD_FIND, 6'd5, 16'hA001, 8'h00, 3'd0, 1'b0, 8'h00));

    for (logic [3:0] c = CMD_RSVD_LO; c <= CMD_RSVD_HI; c++)
      send_cmd(build_cmd(c[2:0], 6'd5, 16'($urandom), 8'($urandom), 3'($urandom),
                         1'($urandom), 8'($urandom)));
    drain_results();

    episode_set = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // dwell on one set for a while so sets fill and lookups hit
      if (n % 12 == 0)
        episode_set = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 7) : $urandom_range(0, 63);
      if (n == 300) hold_rsp = 1'b1;
      if (n == 700) drain_results();
      no_idle = (n % 250) >= 200;
      sig  = ($urandom_range(0, 99) < 65) ? (SIG_POOL ^ 16'($urandom_range(0, 7)))
                                         : 16'($urandom_range(0, 65535));
      wage = ($urandom_range(0, 99) < 30) ? 8'($urandom_range(0, 3)) | {8{$urandom_range(0, 1) == 1}}
                                          : 8'($urandom_range(0, 255));
      send_cmd(build_cmd(pick_cmd(),
                         ($urandom_range(0, 99) < 80) ? 6'(episode_set) : 6'($urandom_range(0, 63)),
                         sig, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                         $urandom_range(0, 99) < 85, wage));
    end

    req_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

### sim.f
rtl/stlru_pkg.sv
rtl/stlru_ram.sv
rtl/stlru_ctrl.sv
rtl/stlru_dpath.sv
rtl/sampler_tag_table_lru.sv
bench/sampler_tag_table_lru_checker.sv
bench/sampler_tag_table_lru_core_tb.sv
